// ===== sv/sphov_pkg.sv =====
// ----------------------------------------------------------------------------
// sphov_pkg: shared types and constants of the sphere overlap insert block
// Field widths, table depth, operation codes, controller states and the
// layout of one stored sphere.
// ----------------------------------------------------------------------------
package sphov_pkg;

   // Table depth and field widths
   localparam int MAX_SPHERES = 1024;
   localparam int COORD_BITS  = 20;
   localparam int RADIUS_BITS = 16;
   localparam int IDX_BITS    = $clog2(MAX_SPHERES);
   localparam int COUNT_BITS  = $clog2(MAX_SPHERES + 1);

   // Stream payload widths, rounded up to whole bytes
   localparam int SPHERE_BITS    = 3 * COORD_BITS + RADIUS_BITS;
   localparam int REQ_TDATA_BITS = ((SPHERE_BITS + 7) / 8) * 8;
   localparam int RSP_BITS       = 3 + COUNT_BITS;
   localparam int RSP_TDATA_BITS = ((RSP_BITS + 7) / 8) * 8;

   // Distance arithmetic widths
   localparam int SQ_BITS  = 2 * COORD_BITS;
   localparam int SUM_BITS = SQ_BITS + 2;
   localparam int RS_BITS  = RADIUS_BITS + 1;
   localparam int LIM_BITS = 2 * RS_BITS;
   localparam int CMP_BITS = (SUM_BITS > LIM_BITS) ? SUM_BITS : LIM_BITS;

   // Operation codes carried in the request tuser
   typedef enum logic [1:0] {
      OP_CHECK         = 2'd0,
      OP_INSERT_FREE   = 2'd1,
      OP_INSERT_ALWAYS = 2'd2,
      OP_CLEAR         = 2'd3
   } sphov_op_type;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } sphov_state_type;

   // One sphere, x in the lowest bits
   typedef struct packed {
      logic        [RADIUS_BITS-1:0] radius;
      logic signed [COORD_BITS-1:0]  z;
      logic signed [COORD_BITS-1:0]  y;
      logic signed [COORD_BITS-1:0]  x;
   } sphov_sphere_type;

   // Status of the distance pipeline towards the controller
   typedef struct packed {
      logic busy;
      logic hit_valid;
      logic hit;
   } sphov_dist_status_type;

endpackage

// ===== sv/sphov_ram.sv =====
// ----------------------------------------------------------------------------
// sphov_ram: simple dual port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module sphov_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/sphov_dist.sv =====
// ----------------------------------------------------------------------------
// sphov_dist: pipelined overlap test
// Four stages: absolute differences and radius sum, squares, sum of the
// squares, strict compare. One stored sphere may enter every cycle.
// ----------------------------------------------------------------------------
module sphov_dist (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   input  sphov_pkg::sphov_sphere_type     stored,
   input  sphov_pkg::sphov_sphere_type     probe,
   output sphov_pkg::sphov_dist_status_type status
);

   import sphov_pkg::*;

   // Magnitude of a difference; it always fits the coordinate width
   function automatic logic [COORD_BITS-1:0] abs_mag(input logic signed [COORD_BITS:0] d);
      logic signed [COORD_BITS:0] n;
      n = d[COORD_BITS] ? -d : d;
      return n[COORD_BITS-1:0];
   endfunction

   logic signed [COORD_BITS:0] diff_x, diff_y, diff_z;

   logic                  v1_ff, v2_ff, v3_ff, v4_ff;
   logic [COORD_BITS-1:0] dx_ff, dy_ff, dz_ff;
   logic [RS_BITS-1:0]    rs_ff;
   logic [SQ_BITS-1:0]    sq_x_in, sq_y_in, sq_z_in;
   logic [SQ_BITS-1:0]    sq_x_ff, sq_y_ff, sq_z_ff;
   logic [LIM_BITS-1:0]   lim_in, lim2_ff, lim3_ff;
   logic [SUM_BITS-1:0]   sum_in, sum_ff;
   logic                  hit_in, hit_ff;

   // Stage one: signed differences with one guard bit
   assign diff_x = (COORD_BITS+1)'(probe.x) - (COORD_BITS+1)'(stored.x);
   assign diff_y = (COORD_BITS+1)'(probe.y) - (COORD_BITS+1)'(stored.y);
   assign diff_z = (COORD_BITS+1)'(probe.z) - (COORD_BITS+1)'(stored.z);

   // Stage two: squares of the distances and of the radius sum
   assign sq_x_in = dx_ff * dx_ff;
   assign sq_y_in = dy_ff * dy_ff;
   assign sq_z_in = dz_ff * dz_ff;
   assign lim_in  = rs_ff * rs_ff;

   // Stage three: squared centre distance
   assign sum_in = SUM_BITS'(sq_x_ff) + SUM_BITS'(sq_y_ff) + SUM_BITS'(sq_z_ff);

   // Stage four: touching spheres do not overlap
   assign hit_in = CMP_BITS'(sum_ff) < CMP_BITS'(lim3_ff);

   // Valid bits of the stages
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   // Payload registers of the stages
   always_ff @(posedge clock) begin
      dx_ff   <= abs_mag(diff_x);
      dy_ff   <= abs_mag(diff_y);
      dz_ff   <= abs_mag(diff_z);
      rs_ff   <= RS_BITS'(probe.radius) + RS_BITS'(stored.radius);
      sq_x_ff <= sq_x_in;
      sq_y_ff <= sq_y_in;
      sq_z_ff <= sq_z_in;
      lim2_ff <= lim_in;
      sum_ff  <= sum_in;
      lim3_ff <= lim2_ff;
      hit_ff  <= hit_in;
   end

   assign status.busy      = v1_ff | v2_ff | v3_ff | v4_ff;
   assign status.hit_valid = v4_ff;
   assign status.hit       = hit_ff;

endmodule

// ===== sv/sphere_overlap_checked_insert.sv =====
// ----------------------------------------------------------------------------
// sphere_overlap_checked_insert: sphere table with overlap checked insert
// Holds up to MAX_SPHERES spheres in one RAM and tests each new sphere
// against all stored ones before an optional insert.
// ----------------------------------------------------------------------------
// Usage
// A request transfer carries the operation in req_tuser and one sphere in
// req_tdata. Every request produces exactly one response transfer with the
// overlap, added and full flags and the number of spheres held afterwards.
// A check or insert reads the stored spheres one per cycle from the single
// RAM read port and streams them through a four stage distance pipeline;
// a clear, or any item on an empty table, skips the scan and goes straight
// to the finishing step. Items are worked on one at a time. The next request
// is taken as soon as the previous response sits in the output register,
// even while the receiver still stalls it; the new item then waits at its
// end until the output register is free. Reset empties the table at once by
// zeroing the entry count; the RAM contents are not cleared and need no
// clearing pass.
// ----------------------------------------------------------------------------
module sphere_overlap_checked_insert (
   input  logic                                 clock,
   input  logic                                 reset,
   // req_tdata, from bit 0: x, y, z, radius, zero fill
   input  logic [sphov_pkg::REQ_TDATA_BITS-1:0] req_tdata,
   // req_tuser: operation
   input  logic [1:0]                           req_tuser,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // rsp_tdata, from bit 0: overlap_found, was_added, table_full,
   // stored_count, zero fill
   output logic [sphov_pkg::RSP_TDATA_BITS-1:0] rsp_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready
);

   import sphov_pkg::*;

   sphov_state_type       state_ff, state_in;
   sphov_op_type          op_ff;
   sphov_sphere_type      probe_ff;
   sphov_sphere_type      stored;
   sphov_dist_status_type dist_status;

   logic [IDX_BITS-1:0]       addr_ff;
   logic [COUNT_BITS-1:0]     count_ff, count_in;
   logic                      rd_vld_ff;
   logic                      hit_ff;
   logic                      rsp_valid_ff;
   logic [RSP_TDATA_BITS-1:0] rsp_data_ff;
   logic [SPHERE_BITS-1:0]    rd_word;

   logic req_fire, scan_last, slot_free, do_insert, is_full;
   logic ram_rd_en, ram_wr_en, finish;

   assign req_fire  = req_tvalid & req_tready;
   assign scan_last = (COUNT_BITS'(addr_ff) + COUNT_BITS'(1)) == count_ff;
   assign slot_free = ~rsp_valid_ff | rsp_tready;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if ((sphov_op_type'(req_tuser) == OP_CLEAR) || (count_ff == '0)) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!rd_vld_ff && !dist_status.busy) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      req_tready = 1'b0;
      ram_rd_en  = 1'b0;
      finish     = 1'b0;
      unique case (state_ff)
         ST_IDLE:   req_tready = 1'b1;
         ST_SCAN:   ram_rd_en  = 1'b1;
         ST_DRAIN:  ;
         ST_FINISH: finish     = slot_free;
         default:   ;
      endcase
   end

   // Insert decision at the end of the scan
   assign do_insert = (op_ff == OP_INSERT_ALWAYS) || ((op_ff == OP_INSERT_FREE) && !hit_ff);
   assign is_full   = do_insert && (count_ff == COUNT_BITS'(MAX_SPHERES));
   assign ram_wr_en = finish && do_insert && !is_full;

   always_comb begin
      if (op_ff == OP_CLEAR) begin
         count_in = '0;
      end else if (ram_wr_en) begin
         count_in = count_ff + COUNT_BITS'(1);
      end else begin
         count_in = count_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rd_vld_ff <= ram_rd_en;
         if (finish) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Item registers, scan address and sticky overlap flag
   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff    <= sphov_op_type'(req_tuser);
         probe_ff <= sphov_sphere_type'(req_tdata[SPHERE_BITS-1:0]);
         addr_ff  <= '0;
         hit_ff   <= 1'b0;
      end else begin
         if (ram_rd_en) begin
            addr_ff <= addr_ff + IDX_BITS'(1);
         end
         if (dist_status.hit_valid && dist_status.hit) begin
            hit_ff <= 1'b1;
         end
      end
      if (finish) begin
         rsp_data_ff <= RSP_TDATA_BITS'({count_in, is_full, ram_wr_en, hit_ff});
      end
   end

   // Sphere table
   sphov_ram #(
      .WIDTH (SPHERE_BITS),
      .DEPTH (MAX_SPHERES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (count_ff[IDX_BITS-1:0]),
      .wr_data (probe_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (addr_ff),
      .rd_data (rd_word)
   );

   assign stored = sphov_sphere_type'(rd_word);

   // Distance pipeline
   sphov_dist u_dist (
      .clock    (clock),
      .reset    (reset),
      .in_valid (rd_vld_ff),
      .stored   (stored),
      .probe    (probe_ff),
      .status   (dist_status)
   );

   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tvalid = rsp_valid_ff;

`ifndef ASSERT_OFF
   // The RAM is never written during a scan
   a_no_wr_during_rd: assert property (@(posedge clock) disable iff (reset)
      !(ram_wr_en && ram_rd_en))
      else $error("RAM write during scan");

   // The entry count never exceeds the table depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_BITS'(MAX_SPHERES))
      else $error("entry count beyond table depth");

   // A new item only starts on an empty distance pipeline
   a_accept_empty: assert property (@(posedge clock) disable iff (reset)
      req_fire |-> (!rd_vld_ff && !dist_status.busy))
      else $error("request accepted with pipeline busy");

   // A response is only raised by the finishing step
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(finish))
      else $error("response raised outside finish");
`endif

endmodule

// ===== tb/sphere_overlap_checked_insert_test.sv =====
// ----------------------------------------------------------------------------
// sphere_overlap_checked_insert_test: self-checking bench for the sphere table
// Drives checks, inserts and clears through the request stream and tracks
// its own copy of the sphere table. Every response transfer is compared
// field by field with the outcome that the tracked table predicts. Random
// idling on both sides, long stalls of the response side, and a final
// phase of back-to-back transfers without idling are included.
// ----------------------------------------------------------------------------
module sphere_overlap_checked_insert_test;
   import sphov_pkg::*;

   // Scoreboard: a copy of the sphere table and the outcomes still awaited
   class sphere_table_tracker;
      typedef struct {
         bit                  overlap;
         bit                  added;
         bit                  full;
         bit [COUNT_BITS-1:0] count;
      } outcome_type;

      logic signed [COORD_BITS-1:0] at_x [MAX_SPHERES];
      logic signed [COORD_BITS-1:0] at_y [MAX_SPHERES];
      logic signed [COORD_BITS-1:0] at_z [MAX_SPHERES];
      logic        [RADIUS_BITS-1:0] at_r [MAX_SPHERES];
      int          held;
      outcome_type awaited_outcomes [$];
      int          errors;
      int          n_requests;
      int          n_overlaps;
      int          n_added;
      int          n_full;
      int          n_clears;

      // Exact squared distance test against every held sphere.
      function bit overlaps_any_stored(longint x, longint y, longint z, longint r);
         longint dx, dy, dz, rs;
         for (int i = 0; i < held; i++) begin
            dx = x - longint'(at_x[i]);
            dy = y - longint'(at_y[i]);
            dz = z - longint'(at_z[i]);
            rs = r + longint'(at_r[i]);
            if (dx * dx + dy * dy + dz * dz < rs * rs) return 1'b1;
         end
         return 1'b0;
      endfunction

      // Applies one accepted request to the table and queues its outcome.
      function void note_request(sphov_op_type op, sphov_sphere_type s);
         outcome_type o;
         o = '{default: 0};
         n_requests++;
         if (op == OP_CLEAR) begin
            held = 0;
            n_clears++;
         end else begin
            o.overlap = overlaps_any_stored(longint'($signed(s.x)), longint'($signed(s.y)),
                                            longint'($signed(s.z)), longint'(s.radius));
            if (op == OP_INSERT_ALWAYS || (op == OP_INSERT_FREE && !o.overlap)) begin
               if (held >= MAX_SPHERES) begin
                  o.full = 1'b1;
               end else begin
                  at_x[held] = s.x;
                  at_y[held] = s.y;
                  at_z[held] = s.z;
                  at_r[held] = s.radius;
                  held++;
                  o.added = 1'b1;
               end
            end
         end
         o.count = COUNT_BITS'(held);
         n_overlaps += o.overlap;
         n_added    += o.added;
         n_full     += o.full;
         awaited_outcomes.insert(awaited_outcomes.size(), o);
      endfunction

      // Compares one response transfer with the oldest awaited outcome.
      function void check_outcome(logic [RSP_TDATA_BITS-1:0] d);
         outcome_type o;
         if (awaited_outcomes.size() == 0) begin
            $error("response transfer with no request outstanding: tdata %h", d);
            errors++;
            return;
         end
         o = awaited_outcomes.pop_front();
         if (d[0] !== o.overlap) begin
            $error("overlap_found: expected %0d, got %0d", o.overlap, d[0]);
            errors++;
         end
         if (d[1] !== o.added) begin
            $error("was_added: expected %0d, got %0d", o.added, d[1]);
            errors++;
         end
         if (d[2] !== o.full) begin
            $error("table_full: expected %0d, got %0d", o.full, d[2]);
            errors++;
         end
         if (d[3 +: COUNT_BITS] !== o.count) begin
            $error("stored_count: expected %0d, got %0d", o.count, d[3 +: COUNT_BITS]);
            errors++;
         end
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic [REQ_TDATA_BITS-1:0] req_tdata = '0;
   logic [1:0]                req_tuser = OP_CHECK;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [RSP_TDATA_BITS-1:0] rsp_tdata;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;

   sphere_table_tracker sb = new();
   bit idling_on    = 1'b1;
   bit hold_request = 1'b0;
   int held_off_cycles = 0;

   sphere_overlap_checked_insert dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   always #6 clock = ~clock;

   // Response monitor: every accepted response transfer is checked.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_outcome(rsp_tdata);
   end

   // Response side: random stall bursts, and one long hold-off on request.
   initial begin
      int burst;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_tready <= 1'b0;
            repeat (79) @(negedge clock);
            held_off_cycles += 80;
            hold_request = 1'b0;
         end else if (idling_on && !reset && $urandom_range(0, 5) == 0) begin
            burst = $urandom_range(1, 7);
            rsp_tready <= 1'b0;
            repeat (burst - 1) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Offers one request transfer, with an optional gap first, and notes it
   // in the tracker once it has been accepted.
   task automatic send_sphere(input sphov_op_type op, input int x, input int y,
                              input int z, input int r);
      sphov_sphere_type s;
      int gap;
      s.x      = x[COORD_BITS-1:0];
      s.y      = y[COORD_BITS-1:0];
      s.z      = z[COORD_BITS-1:0];
      s.radius = r[RADIUS_BITS-1:0];
      if (idling_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 7);
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= REQ_TDATA_BITS'(s);
      do @(posedge clock); while (!req_tready);
      sb.note_request(op, s);
   endtask

   // Run timeout, far beyond the slowest correct run.
   initial begin
      #(12 * 4000000);
      $display("RESULT: ERROR");
      $finish;
   end

   // Stimulus and final verdict
   initial begin
      int           kind, shape, j, axis, rn, delta, extreme;
      int           p [3];
      longint       offset;
      sphov_op_type op;
      int           extremes [4];
      extremes = '{-524288, 524287, 0, -1};

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part: empty table, touching spheres, zero radii, extremes.
      send_sphere(OP_CHECK,         0, 0, 0, 100);
      send_sphere(OP_INSERT_FREE,   0, 0, 0, 100);
      send_sphere(OP_CHECK,         200, 0, 0, 100);
      send_sphere(OP_CHECK,         199, 0, 0, 100);
      send_sphere(OP_INSERT_FREE,   199, 0, 0, 100);
      send_sphere(OP_INSERT_ALWAYS, 199, 0, 0, 100);
      send_sphere(OP_INSERT_ALWAYS, 1000, 1000, 1000, 0);
      send_sphere(OP_CHECK,         1000, 1000, 1000, 0);
      send_sphere(OP_CHECK,         1000, 1000, 1001, 1);
      send_sphere(OP_INSERT_ALWAYS, -524288, -524288, -524288, 65535);
      send_sphere(OP_CHECK,         524287, 524287, 524287, 65535);
      send_sphere(OP_INSERT_FREE,   524287, 524287, 524287, 65535);
      send_sphere(OP_CHECK,         524287, -524288, 0, 65535);
      send_sphere(OP_CHECK,         -1, -1, -1, 65535);
      send_sphere(OP_CLEAR,         -1, -1, -1, 65535);
      send_sphere(OP_CHECK,         0, 0, 0, 65535);
      send_sphere(OP_INSERT_FREE,   0, 0, 0, 0);
      send_sphere(OP_INSERT_FREE,   0, 0, 0, 0);
      send_sphere(OP_CLEAR,         0, 0, 0, 0);

      // Random part: mostly clustered spheres so that hits and misses mix,
      // near-touch probes against held spheres, and full-range noise.
      for (int n = 0; n < 545; n++) begin
         if (n == 60 || n == 400) hold_request = 1'b1;
         kind = $urandom_range(0, 99);
         if (kind < 4) begin
            op = OP_CLEAR;
         end else begin
            kind = $urandom_range(0, 9);
            op = (kind < 3) ? OP_CHECK : (kind < 7) ? OP_INSERT_FREE : OP_INSERT_ALWAYS;
         end
         shape = $urandom_range(0, 99);
         if (shape < 60) begin
            p[0] = $urandom_range(0, 6000) - 3000;
            p[1] = $urandom_range(0, 6000) - 3000;
            p[2] = $urandom_range(0, 6000) - 3000;
            rn   = $urandom_range(0, 600);
         end else if (shape < 80 && sb.held > 0) begin
            // Exactly touching, one closer, or one further along one axis.
            j     = $urandom_range(0, sb.held - 1);
            axis  = $urandom_range(0, 2);
            rn    = $urandom_range(0, 600);
            delta = int'($urandom_range(0, 2)) - 1;
            offset = longint'(rn) + longint'(sb.at_r[j]) + delta;
            if (offset < 0) offset = 0;
            p[0] = int'(sb.at_x[j]);
            p[1] = int'(sb.at_y[j]);
            p[2] = int'(sb.at_z[j]);
            if (p[axis] >= 0) p[axis] = p[axis] - int'(offset);
            else              p[axis] = p[axis] + int'(offset);
         end else begin
            p[0] = $urandom();
            p[1] = $urandom();
            p[2] = $urandom();
            rn   = $urandom_range(0, 65535);
            if ($urandom_range(0, 3) == 0) begin
               extreme = $urandom_range(0, 3);
               p[$urandom_range(0, 2)] = extremes[extreme];
            end
            if ($urandom_range(0, 7) == 0) rn = 65535 * $urandom_range(0, 1);
         end
         send_sphere(op, p[0], p[1], p[2], rn);
      end

      // Last part, without idling: back-to-back inserts into a fresh table,
      // then overlap precedence, duplicates and checks.
      idling_on = 1'b0;
      send_sphere(OP_CLEAR, 0, 0, 0, 0);
      for (int n = 0; n < 12; n++) begin
         send_sphere(OP_INSERT_ALWAYS, $urandom_range(0, 200000), $urandom_range(0, 200000),
                     $urandom_range(0, 200000), $urandom_range(0, 15));
      end
      send_sphere(OP_INSERT_ALWAYS, -500000, -500000, -500000, 3);
      send_sphere(OP_INSERT_FREE,   -500000, -500000, -500000, 3);
      send_sphere(OP_INSERT_FREE, int'(sb.at_x[0]), int'(sb.at_y[0]), int'(sb.at_z[0]), 1);
      send_sphere(OP_INSERT_ALWAYS, int'(sb.at_x[7]), int'(sb.at_y[7]), int'(sb.at_z[7]), 1);
      send_sphere(OP_CHECK,         -500000, -500000, -500000, 3);
      send_sphere(OP_CHECK, int'(sb.at_x[sb.held-1]), int'(sb.at_y[sb.held-1]),
                  int'(sb.at_z[sb.held-1]), 0);
      send_sphere(OP_CLEAR,         0, 0, 0, 0);
      send_sphere(OP_CHECK,         0, 0, 0, 65535);
      @(negedge clock);
      req_tvalid <= 1'b0;

      // Drain the outstanding responses, then allow the block to settle.
      while (sb.awaited_outcomes.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (sb.awaited_outcomes.size() != 0) begin
         $error("%0d responses never arrived", sb.awaited_outcomes.size());
         sb.errors++;
      end

      $display("Covered %0d requests: %0d overlaps, %0d stored, %0d refused, %0d clears.",
               sb.n_requests, sb.n_overlaps, sb.n_added, sb.n_full, sb.n_clears);
      $display("Response side held off for %0d cycles in total; the run ended unthrottled.",
               held_off_cycles);
      if (sb.errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== files.f =====
sv/sphov_pkg.sv
sv/sphov_ram.sv
sv/sphov_dist.sv
sv/sphere_overlap_checked_insert.sv
tb/sphere_overlap_checked_insert_test.sv
